@@ rtl/pcc_pkg.sv @@
// Shared constants, types and the arctangent table of the polar/Cartesian converter.
package pcc_pkg;

   localparam int ITERATIONS_DEFAULT = 16;
   localparam int ANG_STEPS          = 24;
   localparam int IN_W               = 16;
   localparam int OUT_W              = 17;
   localparam int FRAC_W             = 16;
   // Coordinates in Q.16 need 34 bits at full gain; two bits of margin.
   localparam int COORD_W            = 36;
   // Binary angle of 32 bits plus headroom for the signed residual.
   localparam int ANGLE_W            = 34;
   localparam int GAIN_Q30           = 652032874;
   localparam int GAIN_W             = 31;
   localparam int GAIN_SHIFT         = 46;
   localparam int SPLIT_W            = 18;
   localparam int OUT_LIMIT          = 46341;

   typedef enum logic {
      OP_TO_POLAR = 1'b0,
      OP_TO_CART  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                 mode;
      logic                       undef;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [ANGLE_W-1:0]  z;
   } rot_state_type;

   // atan(2^-i) in units of 2*pi / 2^32, rounded to nearest.
   function automatic logic [31:0] arc_of(input int idx);
      logic [31:0] arc;
      case (idx)
         0:  arc = 32'd536870912;
         1:  arc = 32'd316933406;
         2:  arc = 32'd167458907;
         3:  arc = 32'd85004756;
         4:  arc = 32'd42667331;
         5:  arc = 32'd21354465;
         6:  arc = 32'd10679838;
         7:  arc = 32'd5340245;
         8:  arc = 32'd2670163;
         9:  arc = 32'd1335087;
         10: arc = 32'd667544;
         11: arc = 32'd333772;
         12: arc = 32'd166886;
         13: arc = 32'd83443;
         14: arc = 32'd41722;
         15: arc = 32'd20861;
         16: arc = 32'd10430;
         17: arc = 32'd5215;
         18: arc = 32'd2608;
         19: arc = 32'd1304;
         20: arc = 32'd652;
         21: arc = 32'd326;
         22: arc = 32'd163;
         23: arc = 32'd81;
         default: arc = 32'd0;
      endcase
      return arc;
   endfunction

endpackage

@@ rtl/pcc_channels.sv @@
// Valid/ready channel interfaces for the converter's request and response sides.
interface pcc_req_if import pcc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic signed [IN_W-1:0]  in_first;
   logic signed [IN_W-1:0]  in_second;

   modport source (output valid, output opcode, output in_first, output in_second,
                   input ready);
   modport sink   (input valid, input opcode, input in_first, input in_second,
                   output ready);
endinterface

interface pcc_rsp_if import pcc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  out_first;
   logic signed [OUT_W-1:0]  out_second;
   logic                     angle_undefined;

   modport source (output valid, output out_first, output out_second,
                   output angle_undefined, input ready);
   modport sink   (input valid, input out_first, input out_second,
                   input angle_undefined, output ready);
endinterface

@@ rtl/pcc_rot_stage.sv @@
// One registered CORDIC micro-rotation stage with its own valid bit.
module pcc_rot_stage import pcc_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  rot_state_type  in_state,
   output logic           up_take,
   input  logic           dn_take,
   output logic           out_valid,
   output rot_state_type  out_state
);

   logic                       valid_ff;
   rot_state_type              state_ff;
   rot_state_type              state_in;
   logic signed [COORD_W-1:0]  xs;
   logic signed [COORD_W-1:0]  ys;
   logic signed [COORD_W-1:0]  sa;
   logic signed [COORD_W-1:0]  sb;
   logic signed [ANGLE_W-1:0]  arc;
   logic                       ccw;

   assign up_take = !valid_ff || dn_take;

   always_comb begin
      xs  = in_state.x;
      ys  = in_state.y;
      sa  = xs >>> STAGE;
      sb  = ys >>> STAGE;
      arc = {{(ANGLE_W-32){1'b0}}, arc_of(STAGE)};
      // Vectoring drives y toward zero; rotation drives the residual angle toward zero.
      if (in_state.mode == OP_TO_CART) begin
         ccw = !in_state.z[ANGLE_W-1];
      end else begin
         ccw = ys[COORD_W-1];
      end
      state_in = in_state;
      if (ccw) begin
         state_in.x = xs - sb;
         state_in.y = ys + sa;
         state_in.z = in_state.z - arc;
      end else begin
         state_in.x = xs + sb;
         state_in.y = ys - sa;
         state_in.z = in_state.z + arc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_take) begin
         valid_ff <= in_valid;
      end
      if (up_take) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

@@ rtl/polar_cartesian_converter.sv @@
// Top level of the pipelined CORDIC polar/Cartesian coordinate converter.
//
// Requests arrive on req_ch (opcode, in_first, in_second) and results leave on
// rsp_ch (out_first, out_second, angle_undefined); a transfer happens on any
// rising clock edge where valid and ready are both high. Opcode 0 turns (x, y)
// into a radius and a binary angle (32768 = pi); opcode 1 turns a radius and a
// binary angle back into (x, y). The origin in opcode 0 returns zeros with
// angle_undefined set.
//
// Every stage holds one item, so one transfer per cycle is sustained while the
// receiver keeps ready high. A request taken on req_ch passes through one
// folding stage, one stage per micro-rotation, a stage of split gain
// multipliers, a stage that sums and rounds the partial products, and the
// clamping output register before it appears on rsp_ch.
//
// When the receiver holds ready low the output register keeps its result and
// each stage behind it keeps loading until it meets a full stage, so bubbles
// are squeezed out and nothing is dropped or sent twice. req_ch.ready falls
// only when every stage is full. Synchronous reset clears all valid bits and
// holds req_ch.ready low while it is high; the datapath registers are not reset.
module polar_cartesian_converter import pcc_pkg::*; #(
   parameter int ITERATIONS = ITERATIONS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pcc_req_if.sink    req_ch,
   pcc_rsp_if.source  rsp_ch
);

   localparam int STEPS   = (ITERATIONS > ANG_STEPS) ? ANG_STEPS : ITERATIONS;
   localparam int PH_W    = COORD_W - SPLIT_W + GAIN_W;
   localparam int PL_W    = SPLIT_W + 1 + GAIN_W;
   localparam int SUM_W   = COORD_W + GAIN_W + 1;
   localparam int RES_W   = SUM_W - GAIN_SHIFT;
   localparam int EXT_W   = COORD_W - (IN_W + 1) - FRAC_W;

   localparam logic signed [GAIN_W-1:0] GAIN_C  = GAIN_W'(GAIN_Q30);
   localparam logic signed [SUM_W-1:0]  ROUND_C = SUM_W'(1) <<< (GAIN_SHIFT - 1);
   localparam logic signed [RES_W-1:0]  LIM_HI  = RES_W'(OUT_LIMIT);
   localparam logic signed [RES_W-1:0]  LIM_LO  = -LIM_HI;

   // ---------------------------------------------------------------------------
   // Handshake chain: a stage loads when it is empty or the next stage loads.
   // ---------------------------------------------------------------------------
   logic           take_out;
   logic           take_m2;
   logic           take_m1;
   logic           take [0:STEPS];
   logic           vld  [0:STEPS];
   rot_state_type  st   [0:STEPS];

   // ---------------------------------------------------------------------------
   // Folding stage: move the point into the right half plane (opcode 0) or the
   // angle into the front half (opcode 1), and scale to Q.16.
   // ---------------------------------------------------------------------------
   logic                       pre_vld_ff;
   rot_state_type              pre_ff;
   rot_state_type              pre_in;
   logic signed [IN_W:0]       a_ext;
   logic signed [IN_W:0]       b_ext;
   logic signed [IN_W:0]       xa;
   logic signed [IN_W:0]       yb;
   logic [31:0]                ang32;
   logic                       fold;

   assign take[0]      = !pre_vld_ff || take[1];
   assign req_ch.ready = take[0] && !reset;

   always_comb begin
      a_ext  = {req_ch.in_first[IN_W-1], req_ch.in_first};
      b_ext  = {req_ch.in_second[IN_W-1], req_ch.in_second};
      ang32  = {req_ch.in_second, {FRAC_W{1'b0}}};
      pre_in = '0;
      if (opcode_type'(req_ch.opcode) == OP_TO_POLAR) begin
         fold         = a_ext[IN_W];
         xa           = fold ? -a_ext : a_ext;
         yb           = fold ? -b_ext : b_ext;
         pre_in.mode  = OP_TO_POLAR;
         pre_in.undef = (a_ext == '0) && (b_ext == '0);
         // A point in the left half plane starts with the accumulator at pi.
         pre_in.z     = fold ? {{(ANGLE_W-32){1'b0}}, 32'h8000_0000} : '0;
         pre_in.y     = {{EXT_W{yb[IN_W]}}, yb, {FRAC_W{1'b0}}};
      end else begin
         // Angles in the second or third quadrant are turned by pi first.
         fold         = ang32[31] ^ ang32[30];
         xa           = fold ? -a_ext : a_ext;
         yb           = '0;
         ang32[31]    = ang32[31] ^ fold;
         pre_in.mode  = OP_TO_CART;
         pre_in.undef = 1'b0;
         pre_in.z     = {{(ANGLE_W-32){ang32[31]}}, ang32};
         pre_in.y     = '0;
      end
      pre_in.x = {{EXT_W{xa[IN_W]}}, xa, {FRAC_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (take[0]) begin
         pre_vld_ff <= req_ch.valid;
      end
      if (take[0]) begin
         pre_ff <= pre_in;
      end
   end

   assign vld[0] = pre_vld_ff;
   assign st[0]  = pre_ff;

   // ---------------------------------------------------------------------------
   // Micro-rotation stages.
   // ---------------------------------------------------------------------------
   for (genvar k = 0; k < STEPS; k++) begin : g_rot
      logic dn_take;
      if (k == STEPS - 1) begin : g_last
         assign dn_take = take_m1;
      end else begin : g_mid
         assign dn_take = take[k+2];
      end
      pcc_rot_stage #(
         .STAGE (k)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[k]),
         .in_state  (st[k]),
         .up_take   (take[k+1]),
         .dn_take   (dn_take),
         .out_valid (vld[k+1]),
         .out_state (st[k+1])
      );
   end

   // ---------------------------------------------------------------------------
   // Gain stage 1: each coordinate is split into a signed high part and an
   // unsigned low part so that no multiplier exceeds 18 x 31 bits.
   // ---------------------------------------------------------------------------
   logic                       m1_vld_ff;
   opcode_type                 m1_mode_ff;
   logic                       m1_undef_ff;
   logic [31:0]                m1_ang_ff;
   logic signed [PH_W-1:0]     pxh_ff;
   logic signed [PL_W-1:0]     pxl_ff;
   logic signed [PH_W-1:0]     pyh_ff;
   logic signed [PL_W-1:0]     pyl_ff;
   logic signed [PH_W-1:0]     pxh_in;
   logic signed [PL_W-1:0]     pxl_in;
   logic signed [PH_W-1:0]     pyh_in;
   logic signed [PL_W-1:0]     pyl_in;
   logic signed [COORD_W-SPLIT_W-1:0] xh;
   logic signed [COORD_W-SPLIT_W-1:0] yh;
   logic signed [SPLIT_W:0]    xl;
   logic signed [SPLIT_W:0]    yl;

   assign take_m1 = !m1_vld_ff || take_m2;

   always_comb begin
      xh     = st[STEPS].x[COORD_W-1:SPLIT_W];
      yh     = st[STEPS].y[COORD_W-1:SPLIT_W];
      xl     = {1'b0, st[STEPS].x[SPLIT_W-1:0]};
      yl     = {1'b0, st[STEPS].y[SPLIT_W-1:0]};
      pxh_in = PH_W'(xh * GAIN_C);
      pxl_in = PL_W'(xl * GAIN_C);
      pyh_in = PH_W'(yh * GAIN_C);
      pyl_in = PL_W'(yl * GAIN_C);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (take_m1) begin
         m1_vld_ff <= vld[STEPS];
      end
      if (take_m1) begin
         m1_mode_ff  <= st[STEPS].mode;
         m1_undef_ff <= st[STEPS].undef;
         m1_ang_ff   <= st[STEPS].z[31:0];
         pxh_ff      <= pxh_in;
         pxl_ff      <= pxl_in;
         pyh_ff      <= pyh_in;
         pyl_ff      <= pyl_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Gain stage 2: recombine, round to nearest and drop the fraction; round
   // the accumulated angle to 16 bits.
   // ---------------------------------------------------------------------------
   logic                       m2_vld_ff;
   opcode_type                 m2_mode_ff;
   logic                       m2_undef_ff;
   logic [IN_W-1:0]            m2_ang_ff;
   logic signed [RES_W-1:0]    rx_ff;
   logic signed [RES_W-1:0]    ry_ff;
   logic signed [SUM_W-1:0]    sum_x;
   logic signed [SUM_W-1:0]    sum_y;
   logic [31:0]                ang_round;

   assign take_m2 = !m2_vld_ff || take_out;

   always_comb begin
      sum_x     = (SUM_W'(pxh_ff) <<< SPLIT_W) + SUM_W'(pxl_ff) + ROUND_C;
      sum_y     = (SUM_W'(pyh_ff) <<< SPLIT_W) + SUM_W'(pyl_ff) + ROUND_C;
      ang_round = m1_ang_ff + 32'h0000_8000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (take_m2) begin
         m2_vld_ff <= m1_vld_ff;
      end
      if (take_m2) begin
         m2_mode_ff  <= m1_mode_ff;
         m2_undef_ff <= m1_undef_ff;
         m2_ang_ff   <= ang_round[31:16];
         rx_ff       <= sum_x[SUM_W-1:GAIN_SHIFT];
         ry_ff       <= sum_y[SUM_W-1:GAIN_SHIFT];
      end
   end

   // ---------------------------------------------------------------------------
   // Output register: clamp and select the fields for the opcode. The radius
   // never goes negative, so the symmetric clamp serves both opcodes.
   // ---------------------------------------------------------------------------
   logic                       rsp_vld_ff;
   opcode_type                 out_mode_ff;
   logic                       undef_ff;
   logic signed [OUT_W-1:0]    out_first_ff;
   logic signed [OUT_W-1:0]    out_second_ff;
   logic signed [OUT_W-1:0]    out_first_in;
   logic signed [OUT_W-1:0]    out_second_in;

   function automatic logic signed [OUT_W-1:0] clamp_res(input logic signed [RES_W-1:0] v);
      logic signed [RES_W-1:0] c;
      c = v;
      if (v > LIM_HI) begin
         c = LIM_HI;
      end else if (v < LIM_LO) begin
         c = LIM_LO;
      end
      return c[OUT_W-1:0];
   endfunction

   assign take_out = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      if (m2_mode_ff == OP_TO_POLAR) begin
         if (m2_undef_ff) begin
            out_first_in  = '0;
            out_second_in = '0;
         end else begin
            out_first_in  = clamp_res(rx_ff);
            out_second_in = {m2_ang_ff[IN_W-1], m2_ang_ff};
         end
      end else begin
         out_first_in  = clamp_res(rx_ff);
         out_second_in = clamp_res(ry_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (take_out) begin
         rsp_vld_ff <= m2_vld_ff;
      end
      if (take_out) begin
         out_mode_ff   <= m2_mode_ff;
         undef_ff      <= m2_undef_ff && (m2_mode_ff == OP_TO_POLAR);
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.out_first       = out_first_ff;
   assign rsp_ch.out_second      = out_second_ff;
   assign rsp_ch.angle_undefined = undef_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_vld_ff)
      else $error("output register holds a result right after reset");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_vld_ff && !rsp_ch.ready))
      else $error("request side stalled while the output side moves");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && undef_ff) |-> (out_first_ff == '0 && out_second_ff == '0
                                    && out_mode_ff == OP_TO_POLAR))
      else $error("origin result carries a nonzero field or wrong opcode");

   a_radius_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && out_mode_ff == OP_TO_POLAR) |-> !out_first_ff[OUT_W-1])
      else $error("negative radius");

   a_output_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (out_first_ff <= OUT_W'(OUT_LIMIT) && out_first_ff >= -OUT_W'(OUT_LIMIT)
                      && out_second_ff <= OUT_W'(OUT_LIMIT)
                      && out_second_ff >= -OUT_W'(OUT_LIMIT)))
      else $error("result outside the clamp range");

endmodule
